>>> rtl/core/lpd_pkg.sv
package lpd_pkg;

  localparam int MaxSymbols  = 1024;
  localparam int MaxPackets  = 2048;
  localparam int MaxDegree   = 64;
  localparam int SymbolWidth = 8;

  localparam int SymAw = $clog2(MaxSymbols);
  localparam int PktAw = $clog2(MaxPackets);
  localparam int IncAw = $clog2(MaxDegree);
  localparam int DegW  = $clog2(MaxDegree + 1);
  localparam int NbrAw = PktAw + IncAw;
  localparam int CntW  = $clog2(MaxSymbols + 1);

  localparam logic CmdElement = 1'b0;
  localparam logic CmdRead    = 1'b1;

  localparam logic [10:0] SymbolCountReset = 11'd1000;

  typedef struct packed {
    logic       cmd;
    logic [9:0] symbol_index;
    logic [7:0] packet_value;
    logic       last_neighbor;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic        read_known;
    logic [10:0] solved_count;
    logic        all_solved;
    logic        table_full;
  } out_t;

endpackage

>>> rtl/core/lpd_ram.sv
module lpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/lt_peeling_decoder.sv
// A read looks up the symbol store and returns its result word; a non-final neighbor is
// merged into the incoming neighbor list by a walk over that list.
// A final neighbor adds a pass over that list and, for a degree-one packet, a ripple that
// walks the 2048-slot packet table once for every recovered symbol, or else stores the
// packet in a free slot if one is left; one word is in flight at a time.
// After reset a clearing pass empties the symbol and packet stores.
module lt_peeling_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  lpd_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output lpd_pkg::out_t out_data_o,
  input  logic         cfg_we_i,
  input  logic [10:0]  cfg_data_i
);
  import lpd_pkg::*;

  localparam int ValW = SymbolWidth;
  localparam int SymW = ValW + 1;
  localparam int PktW = DegW + ValW;
  localparam logic [PktAw-1:0] PLast = PktAw'(MaxPackets - 1);

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_RD_B,
    S_EL_A, S_EL_B, S_EL_C, S_EL_D, S_EL_END,
    S_FP_A, S_FP_B, S_FP_C, S_FP_E, S_FP_F, S_FP_DONE, S_FP_ONE,
    S_FS_A, S_FS_B, S_CP_A, S_CP_B,
    S_RP_POP, S_RP_S, S_RP_V,
    S_PK_A, S_PK_B, S_PK_N, S_SR_A, S_SR_B,
    S_RM_A, S_RM_B, S_RM_C, S_RM_D, S_RM_E,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [PktAw-1:0]  clr_q;
  logic [SymAw-1:0]  idx_q;
  logic              last_q;
  logic [ValW-1:0]   val_q;
  logic [DegW-1:0]   ideg_q;
  logic [DegW-1:0]   k_q;
  logic [PktAw-1:0]  p_q;
  logic [DegW-1:0]   pdeg_q;
  logic [ValW-1:0]   pval_q;
  logic [SymAw-1:0]  s_q;
  logic [ValW-1:0]   rv_q;
  logic [SymAw-1:0]  n_q;
  logic [CntW-1:0]   head_q;
  logic [CntW-1:0]   tail_q;
  logic [CntW-1:0]   solved_q;
  logic              full_q;
  logic [10:0]       symcnt_q;
  logic              res_known_q;
  logic [ValW-1:0]   res_val_q;
  logic              out_valid_q;
  out_t              out_q;

  logic              sym_we;
  logic [SymAw-1:0]  sym_waddr, sym_raddr;
  logic [SymW-1:0]   sym_wdata, sym_rd;
  logic              pkt_we;
  logic [PktAw-1:0]  pkt_waddr, pkt_raddr;
  logic [PktW-1:0]   pkt_wdata, pkt_rd;
  logic              nbr_we;
  logic [NbrAw-1:0]  nbr_waddr, nbr_raddr;
  logic [SymAw-1:0]  nbr_wdata, nbr_rd;
  logic              inc_we;
  logic [IncAw-1:0]  inc_waddr, inc_raddr;
  logic [SymAw-1:0]  inc_wdata, inc_rd;
  logic              que_we;
  logic [SymAw-1:0]  que_waddr, que_raddr;
  logic [SymAw-1:0]  que_wdata, que_rd;

  logic [DegW-1:0]   ideg_m1, pdeg_m1, pkt_rd_deg;
  logic [ValW-1:0]   pkt_rd_val;
  logic              push_ok;

  assign ideg_m1    = ideg_q - DegW'(1);
  assign pdeg_m1    = pdeg_q - DegW'(1);
  assign pkt_rd_deg = pkt_rd[PktW-1 -: DegW];
  assign pkt_rd_val = pkt_rd[ValW-1:0];
  // A stored packet that falls to one neighbor recovers it only if it is new and fits.
  assign push_ok    = !sym_rd[ValW] && (tail_q < CntW'(MaxSymbols));

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sym_we = 1'b0; sym_waddr = '0; sym_wdata = '0; sym_raddr = '0;
    pkt_we = 1'b0; pkt_waddr = '0; pkt_wdata = '0; pkt_raddr = '0;
    nbr_we = 1'b0; nbr_waddr = '0; nbr_wdata = '0; nbr_raddr = '0;
    inc_we = 1'b0; inc_waddr = '0; inc_wdata = '0; inc_raddr = '0;
    que_we = 1'b0; que_waddr = '0; que_wdata = '0; que_raddr = '0;
    unique case (state_q)
      S_CLEAR: begin
        sym_we    = 1'b1;
        sym_waddr = clr_q[SymAw-1:0];
        pkt_we    = 1'b1;
        pkt_waddr = clr_q;
      end
      S_RD_A: sym_raddr = idx_q;
      S_EL_A: begin
        if (k_q == ideg_q) begin
          if (ideg_q < DegW'(MaxDegree)) begin
            inc_we    = 1'b1;
            inc_waddr = ideg_q[IncAw-1:0];
            inc_wdata = idx_q;
          end
        end else begin
          inc_raddr = k_q[IncAw-1:0];
        end
      end
      S_EL_C, S_FP_E: inc_raddr = ideg_m1[IncAw-1:0];
      S_EL_D, S_FP_F: begin
        inc_we    = 1'b1;
        inc_waddr = k_q[IncAw-1:0];
        inc_wdata = inc_rd;
      end
      S_FP_A, S_CP_A: inc_raddr = k_q[IncAw-1:0];
      S_FP_B: sym_raddr = inc_rd;
      S_FP_DONE: inc_raddr = '0;
      S_FP_ONE: begin
        sym_we    = 1'b1;
        sym_waddr = inc_rd;
        sym_wdata = {1'b1, val_q};
        que_we    = 1'b1;
        que_waddr = '0;
        que_wdata = inc_rd;
      end
      S_FS_A, S_PK_A: pkt_raddr = p_q;
      S_FS_B: begin
        if (pkt_rd_deg == '0) begin
          pkt_we    = 1'b1;
          pkt_waddr = p_q;
          pkt_wdata = {ideg_q, val_q};
        end
      end
      S_CP_B: begin
        nbr_we    = 1'b1;
        nbr_waddr = {p_q, k_q[IncAw-1:0]};
        nbr_wdata = inc_rd;
      end
      S_RP_POP: que_raddr = head_q[SymAw-1:0];
      S_RP_S: sym_raddr = que_rd;
      S_SR_A: nbr_raddr = {p_q, k_q[IncAw-1:0]};
      S_RM_A: nbr_raddr = {p_q, pdeg_m1[IncAw-1:0]};
      S_RM_B: begin
        nbr_we    = 1'b1;
        nbr_waddr = {p_q, k_q[IncAw-1:0]};
        nbr_wdata = nbr_rd;
        if (pdeg_m1 != DegW'(1)) begin
          pkt_we    = 1'b1;
          pkt_waddr = p_q;
          pkt_wdata = {pdeg_m1, pval_q ^ rv_q};
        end
      end
      S_RM_C: nbr_raddr = {p_q, IncAw'(0)};
      S_RM_D: begin
        pkt_we    = 1'b1;
        pkt_waddr = p_q;
        pkt_wdata = {DegW'(0), pval_q};
        sym_raddr = nbr_rd;
      end
      S_RM_E: begin
        if (push_ok) begin
          sym_we    = 1'b1;
          sym_waddr = n_q;
          sym_wdata = {1'b1, pval_q};
          que_we    = 1'b1;
          que_waddr = tail_q[SymAw-1:0];
          que_wdata = n_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      val_q       <= '0;
      ideg_q      <= '0;
      k_q         <= '0;
      p_q         <= '0;
      pdeg_q      <= '0;
      pval_q      <= '0;
      s_q         <= '0;
      rv_q        <= '0;
      n_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      solved_q    <= '0;
      full_q      <= 1'b0;
      symcnt_q    <= SymbolCountReset;
      res_known_q <= 1'b0;
      res_val_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        symcnt_q <= cfg_data_i;
      end
      // The emit state loads a new word whenever the old one leaves.
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PktAw'(1);
          if (clr_q == PLast) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= in_data_i.symbol_index;
            last_q  <= in_data_i.last_neighbor;
            val_q   <= in_data_i.packet_value;
            k_q     <= '0;
            state_q <= (in_data_i.cmd == CmdRead) ? S_RD_A : S_EL_A;
          end
        end
        S_RD_A: state_q <= S_RD_B;
        S_RD_B: begin
          res_known_q <= sym_rd[ValW];
          res_val_q   <= sym_rd[ValW] ? sym_rd[ValW-1:0] : '0;
          state_q     <= S_EMIT;
        end
        S_EL_A: begin
          if (k_q == ideg_q) begin
            if (ideg_q < DegW'(MaxDegree)) ideg_q <= ideg_q + DegW'(1);
            state_q <= S_EL_END;
          end else begin
            state_q <= S_EL_B;
          end
        end
        S_EL_B: begin
          // A repeated neighbor cancels the earlier one.
          if (inc_rd == idx_q) begin
            state_q <= S_EL_C;
          end else begin
            k_q     <= k_q + DegW'(1);
            state_q <= S_EL_A;
          end
        end
        S_EL_C: state_q <= S_EL_D;
        S_EL_D: begin
          ideg_q  <= ideg_m1;
          state_q <= S_EL_END;
        end
        S_EL_END: begin
          if (last_q) begin
            k_q         <= '0;
            res_known_q <= 1'b0;
            res_val_q   <= '0;
            state_q     <= S_FP_A;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FP_A: state_q <= (k_q == ideg_q) ? S_FP_DONE : S_FP_B;
        S_FP_B: state_q <= S_FP_C;
        S_FP_C: begin
          if (sym_rd[ValW]) begin
            val_q   <= val_q ^ sym_rd[ValW-1:0];
            state_q <= S_FP_E;
          end else begin
            k_q     <= k_q + DegW'(1);
            state_q <= S_FP_A;
          end
        end
        S_FP_E: state_q <= S_FP_F;
        S_FP_F: begin
          ideg_q  <= ideg_m1;
          state_q <= S_FP_A;
        end
        S_FP_DONE: begin
          if (ideg_q == DegW'(1)) begin
            state_q <= S_FP_ONE;
          end else if (ideg_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            p_q     <= '0;
            state_q <= S_FS_A;
          end
        end
        S_FP_ONE: begin
          solved_q <= solved_q + CntW'(1);
          head_q   <= '0;
          tail_q   <= CntW'(1);
          ideg_q   <= '0;
          state_q  <= S_RP_POP;
        end
        S_FS_A: state_q <= S_FS_B;
        S_FS_B: begin
          if (pkt_rd_deg == '0) begin
            k_q     <= '0;
            state_q <= S_CP_A;
          end else if (p_q == PLast) begin
            full_q  <= 1'b1;
            ideg_q  <= '0;
            state_q <= S_EMIT;
          end else begin
            p_q     <= p_q + PktAw'(1);
            state_q <= S_FS_A;
          end
        end
        S_CP_A: begin
          if (k_q == ideg_q) begin
            ideg_q  <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_CP_B;
          end
        end
        S_CP_B: begin
          k_q     <= k_q + DegW'(1);
          state_q <= S_CP_A;
        end
        S_RP_POP: state_q <= (head_q == tail_q) ? S_EMIT : S_RP_S;
        S_RP_S: begin
          s_q     <= que_rd;
          head_q  <= head_q + CntW'(1);
          state_q <= S_RP_V;
        end
        S_RP_V: begin
          rv_q    <= sym_rd[ValW-1:0];
          p_q     <= '0;
          state_q <= S_PK_A;
        end
        S_PK_A: state_q <= S_PK_B;
        S_PK_B: begin
          pdeg_q <= pkt_rd_deg;
          pval_q <= pkt_rd_val;
          k_q    <= '0;
          state_q <= (pkt_rd_deg == '0) ? S_PK_N : S_SR_A;
        end
        S_PK_N: begin
          if (p_q == PLast) begin
            state_q <= S_RP_POP;
          end else begin
            p_q     <= p_q + PktAw'(1);
            state_q <= S_PK_A;
          end
        end
        S_SR_A: state_q <= (k_q == pdeg_q) ? S_PK_N : S_SR_B;
        S_SR_B: begin
          if (nbr_rd == s_q) begin
            state_q <= S_RM_A;
          end else begin
            k_q     <= k_q + DegW'(1);
            state_q <= S_SR_A;
          end
        end
        S_RM_A: state_q <= S_RM_B;
        S_RM_B: begin
          pval_q  <= pval_q ^ rv_q;
          pdeg_q  <= pdeg_m1;
          state_q <= (pdeg_m1 == DegW'(1)) ? S_RM_C : S_PK_N;
        end
        S_RM_C: state_q <= S_RM_D;
        S_RM_D: begin
          n_q     <= nbr_rd;
          state_q <= S_RM_E;
        end
        S_RM_E: begin
          if (push_ok) begin
            solved_q <= solved_q + CntW'(1);
            tail_q   <= tail_q + CntW'(1);
          end
          state_q <= S_PK_N;
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.read_value   <= res_val_q;
            out_q.read_known   <= res_known_q;
            out_q.solved_count <= solved_q;
            out_q.all_solved   <= (solved_q == symcnt_q);
            out_q.table_full   <= full_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  lpd_ram #(.WIDTH(SymW), .DEPTH(MaxSymbols)) u_sym_ram (
    .clk_i, .we_i(sym_we), .waddr_i(sym_waddr), .wdata_i(sym_wdata),
    .raddr_i(sym_raddr), .rdata_o(sym_rd)
  );

  lpd_ram #(.WIDTH(PktW), .DEPTH(MaxPackets)) u_pkt_ram (
    .clk_i, .we_i(pkt_we), .waddr_i(pkt_waddr), .wdata_i(pkt_wdata),
    .raddr_i(pkt_raddr), .rdata_o(pkt_rd)
  );

  lpd_ram #(.WIDTH(SymAw), .DEPTH(MaxPackets * MaxDegree)) u_nbr_ram (
    .clk_i, .we_i(nbr_we), .waddr_i(nbr_waddr), .wdata_i(nbr_wdata),
    .raddr_i(nbr_raddr), .rdata_o(nbr_rd)
  );

  lpd_ram #(.WIDTH(SymAw), .DEPTH(MaxDegree)) u_inc_ram (
    .clk_i, .we_i(inc_we), .waddr_i(inc_waddr), .wdata_i(inc_wdata),
    .raddr_i(inc_raddr), .rdata_o(inc_rd)
  );

  lpd_ram #(.WIDTH(SymAw), .DEPTH(MaxSymbols)) u_que_ram (
    .clk_i, .we_i(que_we), .waddr_i(que_waddr), .wdata_i(que_wdata),
    .raddr_i(que_raddr), .rdata_o(que_rd)
  );

`ifndef ASSERT_OFF
  a_solved_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> solved_q >= $past(solved_q))
    else $error("solved count went down");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("ripple queue head passed tail");

  a_degree_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ideg_q <= DegW'(MaxDegree) && pdeg_q <= DegW'(MaxDegree))
    else $error("packet degree out of range");

  a_solved_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    solved_q <= CntW'(MaxSymbols))
    else $error("more symbols solved than exist");
`endif

endmodule
